// ===== hdl/bba_pkg.sv =====
`timescale 1ns / 1ps
package bba_pkg;
  localparam int ORDERS = 16;
  localparam int TOP_ORDER = ORDERS - 1;
  localparam int IDX_W = ORDERS - 1;
  localparam int NBLK = 1 << IDX_W;
  localparam int ORD_W = 4;
  localparam int LINK_W = IDX_W + 1;
  localparam int MIN_BLOCK_BYTES = 64;
  localparam int REQ_W = 22;
  localparam int HDR_W = 6;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_TOO_LARGE = 2'd2,
    ST_BAD_FREE = 2'd3
  } bba_status_t;

  typedef struct packed {
    logic alloc;
    logic [ORD_W-1:0] order;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } bba_entry_t;

  typedef struct packed {
    logic we;
    logic [IDX_W-1:0] waddr;
    bba_entry_t wdata;
    logic [IDX_W-1:0] raddr;
  } bba_mem_req_t;
endpackage

// ===== hdl/bba_table_ram.sv =====
`timescale 1ns / 1ps
module bba_table_ram
  import bba_pkg::*;
(
  input  logic clk,
  input  bba_mem_req_t req,
  output bba_entry_t rdata
);
  bba_entry_t mem [NBLK];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

// ===== hdl/bba_ctrl.sv =====
`timescale 1ns / 1ps
module bba_ctrl
  import bba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic [HDR_W-1:0] hdr,
  input  logic start,
  output logic busy,
  input  logic op,
  input  logic [REQ_W-1:0] req_bytes,
  input  logic [IDX_W-1:0] blk_idx,
  output bba_mem_req_t mreq,
  input  bba_entry_t rd,
  output logic res_valid,
  output logic [1:0] res_status,
  output logic [IDX_W-1:0] res_index,
  output logic [ORD_W-1:0] res_order,
  output logic res_empty
);
  typedef enum logic [22:0] {
    S_IDLE    = 23'd1 << 0,  S_CLEAR  = 23'd1 << 1,  S_A_FIND = 23'd1 << 2,
    S_U_RD    = 23'd1 << 3,  S_U_GET  = 23'd1 << 4,  S_U_P    = 23'd1 << 5,
    S_U_PW    = 23'd1 << 6,  S_U_N    = 23'd1 << 7,  S_U_NW   = 23'd1 << 8,
    S_U_C     = 23'd1 << 9,  S_U_CW   = 23'd1 << 10, S_P_RD   = 23'd1 << 11,
    S_P_W     = 23'd1 << 12, S_P_H    = 23'd1 << 13, S_P_HW   = 23'd1 << 14,
    S_A_SPLIT = 23'd1 << 15, S_A_FIN  = 23'd1 << 16, S_A_FINW = 23'd1 << 17,
    S_F_RD    = 23'd1 << 18, S_F_CHK  = 23'd1 << 19, S_F_LOOP = 23'd1 << 20,
    S_F_BUD   = 23'd1 << 21, S_RET    = 23'd1 << 22
  } state_t;

  typedef enum logic [1:0] {
    RET_A_UNLINK = 2'd0, RET_SPLIT = 2'd1, RET_F_UNLINK = 2'd2, RET_F_PUSH = 2'd3
  } ret_t;

  state_t state_r, state_nxt;
  ret_t ret_r, ret_nxt;
  logic [LINK_W-1:0] heads_r [ORDERS];
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [IDX_W-1:0] u_idx_r, u_idx_nxt, h_r, h_nxt, cur_r, cur_nxt, bi_r, bi_nxt;
  logic [ORD_W-1:0] u_k_r, u_k_nxt, j_r, j_nxt, k_r, k_nxt, orig_r, orig_nxt;
  logic [ORD_W:0] want_r, want_nxt;
  logic [LINK_W-1:0] n_r, n_nxt, p_r, p_nxt, hd_r, hd_nxt;
  logic hw_en;
  logic [ORD_W-1:0] hw_k;
  logic [LINK_W-1:0] hw_val;
  logic fin;
  logic [1:0] fin_status;
  logic [IDX_W-1:0] fin_idx;
  logic [ORD_W-1:0] fin_order;
  logic fin_empty;
  logic [ORD_W:0] want_c;
  logic [ORD_W:0] j_c;
  logic [REQ_W-1:0] sz;
  logic [IDX_W-1:0] bud;
  bba_entry_t wd;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    want_c = (ORD_W+1)'(ORDERS);
    for (int k = ORDERS - 1; k >= 0; k--) begin
      sz = REQ_W'(MIN_BLOCK_BYTES) << k;
      if (sz > REQ_W'(hdr) && req_bytes < sz - REQ_W'(hdr)) want_c = (ORD_W+1)'(k);
    end
    j_c = (ORD_W+1)'(ORDERS);
    for (int k = ORDERS - 1; k >= 0; k--) begin
      if ((ORD_W+1)'(k) >= want_r && heads_r[k][LINK_W-1]) j_c = (ORD_W+1)'(k);
    end
  end

  assign bud = cur_r ^ (IDX_W'(1) << k_r);

  always_comb begin
    state_nxt = state_r; ret_nxt = ret_r; clr_nxt = clr_r;
    u_idx_nxt = u_idx_r; u_k_nxt = u_k_r; h_nxt = h_r; cur_nxt = cur_r; bi_nxt = bi_r;
    j_nxt = j_r; k_nxt = k_r; orig_nxt = orig_r; want_nxt = want_r;
    n_nxt = n_r; p_nxt = p_r; hd_nxt = hd_r;
    hw_en = 1'b0; hw_k = u_k_r; hw_val = '0;
    fin = 1'b0; fin_status = ST_OK; fin_idx = '0; fin_order = '0; fin_empty = 1'b0;
    mreq.we = 1'b0; mreq.waddr = '0; mreq.wdata = '0; mreq.raddr = '0;
    wd = rd;
    unique case (state_r)
      S_CLEAR: begin
        mreq.we = 1'b1;
        mreq.waddr = clr_r;
        mreq.wdata = '0;
        if (clr_r == '0) mreq.wdata.order = ORD_W'(TOP_ORDER);
        clr_nxt = clr_r + 1'b1;
        if (clr_r == IDX_W'(NBLK - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (!op) begin
            want_nxt = want_c;
            if (want_c == (ORD_W+1)'(ORDERS)) begin
              fin = 1'b1; fin_status = ST_TOO_LARGE;
            end else begin
              state_nxt = S_A_FIND;
            end
          end else begin
            bi_nxt = blk_idx;
            state_nxt = S_F_RD;
          end
        end
      end
      S_A_FIND: begin
        if (j_c == (ORD_W+1)'(ORDERS)) begin
          fin = 1'b1; fin_status = ST_NO_SPACE; state_nxt = S_IDLE;
        end else begin
          h_nxt = heads_r[j_c[ORD_W-1:0]][IDX_W-1:0];
          u_idx_nxt = heads_r[j_c[ORD_W-1:0]][IDX_W-1:0];
          u_k_nxt = j_c[ORD_W-1:0];
          j_nxt = j_c[ORD_W-1:0];
          ret_nxt = RET_A_UNLINK;
          state_nxt = S_U_RD;
        end
      end
      // Unlink u_idx from list u_k.
      S_U_RD: begin
        mreq.raddr = u_idx_r; state_nxt = S_U_GET;
      end
      S_U_GET: begin
        n_nxt = rd.next; p_nxt = rd.prev; state_nxt = S_U_P;
      end
      S_U_P: begin
        if (p_r[LINK_W-1]) begin
          mreq.raddr = p_r[IDX_W-1:0]; state_nxt = S_U_PW;
        end else begin
          hw_en = 1'b1; hw_val = n_r; state_nxt = S_U_N;
        end
      end
      S_U_PW: begin
        wd.next = n_r;
        mreq.we = 1'b1; mreq.waddr = p_r[IDX_W-1:0]; mreq.wdata = wd;
        state_nxt = S_U_N;
      end
      S_U_N: begin
        if (n_r[LINK_W-1]) begin
          mreq.raddr = n_r[IDX_W-1:0]; state_nxt = S_U_NW;
        end else begin
          state_nxt = S_U_C;
        end
      end
      S_U_NW: begin
        wd.prev = p_r;
        mreq.we = 1'b1; mreq.waddr = n_r[IDX_W-1:0]; mreq.wdata = wd;
        state_nxt = S_U_C;
      end
      S_U_C: begin
        mreq.raddr = u_idx_r; state_nxt = S_U_CW;
      end
      S_U_CW: begin
        wd.next = '0; wd.prev = '0;
        mreq.we = 1'b1; mreq.waddr = u_idx_r; mreq.wdata = wd;
        state_nxt = S_RET;
      end
      // Push u_idx onto list u_k.
      S_P_RD: begin
        mreq.raddr = u_idx_r; hd_nxt = heads_r[u_k_r]; state_nxt = S_P_W;
      end
      S_P_W: begin
        wd.order = u_k_r; wd.prev = '0; wd.next = hd_r;
        mreq.we = 1'b1; mreq.waddr = u_idx_r; mreq.wdata = wd;
        state_nxt = S_P_H;
      end
      S_P_H: begin
        hw_en = 1'b1; hw_val = {1'b1, u_idx_r};
        if (hd_r[LINK_W-1]) begin
          mreq.raddr = hd_r[IDX_W-1:0]; state_nxt = S_P_HW;
        end else begin
          state_nxt = S_RET;
        end
      end
      S_P_HW: begin
        wd.prev = {1'b1, u_idx_r};
        mreq.we = 1'b1; mreq.waddr = hd_r[IDX_W-1:0]; mreq.wdata = wd;
        state_nxt = S_RET;
      end
      S_RET: begin
        case (ret_r)
          RET_A_UNLINK, RET_SPLIT: state_nxt = S_A_SPLIT;
          RET_F_UNLINK: state_nxt = S_F_LOOP;
          default: begin
            fin = 1'b1; fin_status = ST_OK; fin_idx = bi_r; fin_order = orig_r;
            fin_empty = (k_r == ORD_W'(TOP_ORDER));
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_A_SPLIT: begin
        if ({1'b0, j_r} > want_r) begin
          j_nxt = j_r - 1'b1;
          u_idx_nxt = h_r + (IDX_W'(1) << (j_r - 1'b1));
          u_k_nxt = j_r - 1'b1;
          ret_nxt = RET_SPLIT;
          state_nxt = S_P_RD;
        end else begin
          state_nxt = S_A_FIN;
        end
      end
      S_A_FIN: begin
        mreq.raddr = h_r; state_nxt = S_A_FINW;
      end
      S_A_FINW: begin
        wd.alloc = 1'b1; wd.order = want_r[ORD_W-1:0];
        mreq.we = 1'b1; mreq.waddr = h_r; mreq.wdata = wd;
        fin = 1'b1; fin_status = ST_OK; fin_idx = h_r; fin_order = want_r[ORD_W-1:0];
        state_nxt = S_IDLE;
      end
      S_F_RD: begin
        mreq.raddr = bi_r; state_nxt = S_F_CHK;
      end
      S_F_CHK: begin
        if (!rd.alloc) begin
          fin = 1'b1; fin_status = ST_BAD_FREE; fin_idx = bi_r; state_nxt = S_IDLE;
        end else begin
          wd.alloc = 1'b0;
          mreq.we = 1'b1; mreq.waddr = bi_r; mreq.wdata = wd;
          orig_nxt = rd.order; k_nxt = rd.order; cur_nxt = bi_r;
          state_nxt = S_F_LOOP;
        end
      end
      S_F_LOOP: begin
        if (k_r != ORD_W'(TOP_ORDER)) begin
          mreq.raddr = bud; state_nxt = S_F_BUD;
        end else begin
          u_idx_nxt = cur_r; u_k_nxt = k_r; ret_nxt = RET_F_PUSH; state_nxt = S_P_RD;
        end
      end
      S_F_BUD: begin
        if (rd.alloc || rd.order != k_r) begin
          u_idx_nxt = cur_r; u_k_nxt = k_r; ret_nxt = RET_F_PUSH; state_nxt = S_P_RD;
        end else begin
          u_idx_nxt = bud; u_k_nxt = k_r; ret_nxt = RET_F_UNLINK;
          if (bud < cur_r) cur_nxt = bud;
          k_nxt = k_r + 1'b1;
          state_nxt = S_U_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < ORDERS; i++) heads_r[i] <= '0;
      heads_r[TOP_ORDER] <= {1'b1, IDX_W'(0)};
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      res_valid <= fin;
      if (hw_en) heads_r[hw_k] <= hw_val;
    end
  end

  always_ff @(posedge clk) begin
    ret_r <= ret_nxt; u_idx_r <= u_idx_nxt; u_k_r <= u_k_nxt; h_r <= h_nxt;
    cur_r <= cur_nxt; bi_r <= bi_nxt; j_r <= j_nxt; k_r <= k_nxt; orig_r <= orig_nxt;
    want_r <= want_nxt; n_r <= n_nxt; p_r <= p_nxt; hd_r <= hd_nxt;
    if (fin) begin
      res_status <= fin_status; res_index <= fin_idx;
      res_order <= fin_order; res_empty <= fin_empty;
    end
  end
endmodule

// ===== hdl/buddy_block_allocator_top.sv =====
`timescale 1ns / 1ps
// An allocate reads and rewrites the block table entries it touches, with up to fifteen
// split pushes; a free may take up to fifteen merge steps.
// One item at a time; the next start is taken in the cycle the result strobe is shown.
// Each block table read-modify-write is a read state followed by a write state.
// Reset: synchronous rst_n; then a clearing pass over all 32768 entries keeps busy high.
// The result strobe lasts one cycle and the receiver cannot stall it.
module buddy_block_allocator_top
  import bba_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [HDR_W-1:0] cfg_header_bytes,
  input  logic start,
  output logic busy,
  input  logic in_operation,
  input  logic [REQ_W-1:0] in_request_bytes,
  input  logic [IDX_W-1:0] in_block_index,
  output logic out_valid,
  output logic [1:0] out_status,
  output logic [IDX_W-1:0] out_granted_index,
  output logic [ORD_W-1:0] out_granted_order,
  output logic out_chunk_empty
);
  logic [HDR_W-1:0] hdr_r;
  bba_mem_req_t mreq;
  bba_entry_t rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r <= HDR_W'(12);
    end else if (cfg_valid) begin
      hdr_r <= cfg_header_bytes;
    end
  end

  bba_table_ram u_ram (
    .clk(clk), .req(mreq), .rdata(rdata)
  );

  bba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .hdr(hdr_r), .start(start), .busy(busy),
    .op(in_operation), .req_bytes(in_request_bytes), .blk_idx(in_block_index),
    .mreq(mreq), .rd(rdata), .res_valid(out_valid), .res_status(out_status),
    .res_index(out_granted_index), .res_order(out_granted_order),
    .res_empty(out_chunk_empty)
  );
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import bba_pkg::*;

  typedef struct {
    logic op;
    logic [REQ_W-1:0] req;
    logic [IDX_W-1:0] idx;
    bit pick;  // free one of the blocks currently held
  } job_t;

  typedef struct {
    bba_status_t status;
    logic [IDX_W-1:0] index;
    logic [ORD_W-1:0] order;
    logic empty;
  } grant_t;

  localparam int SETTLE = 400;
  localparam int STALL_LIMIT = 200000;

  logic clk, rst_n;
  logic cfg_valid, cfg_ready;
  logic [HDR_W-1:0] cfg_header_bytes;
  logic start, busy;
  logic in_operation;
  logic [REQ_W-1:0] in_request_bytes;
  logic [IDX_W-1:0] in_block_index;
  logic out_valid;
  logic [1:0] out_status;
  logic [IDX_W-1:0] out_granted_index;
  logic [ORD_W-1:0] out_granted_order;
  logic out_chunk_empty;

  buddy_block_allocator_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_header_bytes(cfg_header_bytes),
    .start(start), .busy(busy),
    .in_operation(in_operation), .in_request_bytes(in_request_bytes),
    .in_block_index(in_block_index),
    .out_valid(out_valid), .out_status(out_status),
    .out_granted_index(out_granted_index), .out_granted_order(out_granted_order),
    .out_chunk_empty(out_chunk_empty)
  );

  // Shadow copy of the allocator state.
  bit blk_alloc [NBLK];
  bit [ORD_W-1:0] blk_order [NBLK];
  bit [LINK_W-1:0] blk_next [NBLK];
  bit [LINK_W-1:0] blk_prev [NBLK];
  bit [LINK_W-1:0] free_head [ORDERS];
  int unsigned hdr_bytes;

  job_t pending_jobs[$];
  grant_t grants_due[$];
  logic [IDX_W-1:0] held_blocks[$];
  bit took, idle_ok;
  int errors, stall_cnt;

  function automatic void push_free(int unsigned b, int unsigned k);
    bit [LINK_W-1:0] h;
    h = free_head[k];
    blk_order[b] = ORD_W'(k);
    blk_prev[b] = '0;
    blk_next[b] = h;
    if (h[IDX_W]) blk_prev[h[IDX_W-1:0]] = {1'b1, IDX_W'(b)};
    free_head[k] = {1'b1, IDX_W'(b)};
  endfunction

  function automatic void unlink_free(int unsigned b, int unsigned k);
    bit [LINK_W-1:0] n, p;
    n = blk_next[b];
    p = blk_prev[b];
    if (p[IDX_W]) blk_next[p[IDX_W-1:0]] = n;
    else free_head[k] = n;
    if (n[IDX_W]) blk_prev[n[IDX_W-1:0]] = p;
    blk_next[b] = '0;
    blk_prev[b] = '0;
  endfunction

  function automatic grant_t serve_request(logic op, logic [REQ_W-1:0] req,
                                           logic [IDX_W-1:0] bi);
    grant_t g;
    int unsigned want, j, h, b, bud, orig, k;
    longint unsigned sz;
    g = '{ST_OK, '0, '0, 1'b0};
    if (op == 1'b0) begin
      want = ORDERS;
      for (int i = 0; i < ORDERS; i++) begin
        sz = longint'(MIN_BLOCK_BYTES) << i;
        if (sz > hdr_bytes && req < sz - hdr_bytes) begin
          want = i;
          break;
        end
      end
      if (want == ORDERS) begin
        g.status = ST_TOO_LARGE;
        return g;
      end
      j = want;
      while (j < ORDERS && !free_head[j][IDX_W]) j++;
      if (j == ORDERS) begin
        g.status = ST_NO_SPACE;
        return g;
      end
      h = free_head[j][IDX_W-1:0];
      unlink_free(h, j);
      while (j > want) begin
        j--;
        push_free((h + (1 << j)) & (NBLK - 1), j);
      end
      blk_alloc[h] = 1'b1;
      blk_order[h] = ORD_W'(want);
      g.index = IDX_W'(h);
      g.order = ORD_W'(want);
      held_blocks.push_back(IDX_W'(h));
    end else begin
      g.index = bi;
      if (!blk_alloc[bi]) begin
        g.status = ST_BAD_FREE;
        return g;
      end
      b = bi;
      orig = blk_order[bi];
      k = orig;
      blk_alloc[b] = 1'b0;
      while (k < TOP_ORDER) begin
        bud = (b ^ (1 << k)) & (NBLK - 1);
        if (blk_alloc[bud] || blk_order[bud] != k) break;
        unlink_free(bud, k);
        if (bud < b) b = bud;
        k++;
      end
      push_free(b, k);
      g.order = ORD_W'(orig);
      g.empty = (k == TOP_ORDER);
    end
    return g;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: a new item goes out once the previous one was taken.
  always @(negedge clk) begin
    job_t j;
    int pos;
    if (!start || took) begin
      if (pending_jobs.size() > 0 && !(idle_ok && $urandom_range(0, 99) < 15)) begin
        j = pending_jobs.pop_front();
        if (j.pick && held_blocks.size() > 0) begin
          pos = $urandom_range(0, held_blocks.size() - 1);
          j.idx = held_blocks[pos];
          held_blocks.delete(pos);
        end
        start <= 1'b1;
        in_operation <= j.op;
        in_request_bytes <= j.req;
        in_block_index <= j.idx;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results, then predict for a newly taken item.
  always @(posedge clk) begin
    grant_t want;
    took = 1'b0;
    if (rst_n) begin
      if (out_valid) begin
        if (grants_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: status %0d index %0d", out_status,
                                     out_granted_index);
        end else begin
          want = grants_due.pop_front();
          if (out_status !== want.status || out_granted_index !== want.index ||
              out_granted_order !== want.order || out_chunk_empty !== want.empty) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp st %0d idx %0d ord %0d empty %0d, got %0d %0d %0d %0d",
                       want.status, want.index, want.order, want.empty, out_status,
                       out_granted_index, out_granted_order, out_chunk_empty);
          end
        end
      end
      if (start && !busy) begin
        took = 1'b1;
        grants_due.push_back(serve_request(in_operation, in_request_bytes, in_block_index));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) stall_cnt = 0;
    else stall_cnt++;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic add_job(logic op, int unsigned req, int unsigned idx, bit pick);
    job_t j;
    j.op = op;
    j.req = REQ_W'(req);
    j.idx = IDX_W'(idx);
    j.pick = pick;
    pending_jobs.push_back(j);
  endtask

  task automatic add_random(int n);
    int unsigned r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        if ($urandom_range(0, 19) == 0)
          add_job(1'b0, $urandom_range(0, (1 << REQ_W) - 1), 0, 1'b0);
        else add_job(1'b0, $urandom_range(0, 64 << $urandom_range(0, 9)), 0, 1'b0);
      end else if (r < 90) begin
        add_job(1'b1, 0, $urandom_range(0, NBLK - 1), 1'b1);
      end else begin
        add_job(1'b1, $urandom_range(0, (1 << REQ_W) - 1), $urandom_range(0, NBLK - 1), 1'b0);
      end
    end
  endtask

  // Returns once every queued item has been served and the block has settled.
  task automatic drain();
    do begin
      @(negedge clk);
      #1;
    end while (pending_jobs.size() > 0 || start || grants_due.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_header(int unsigned v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_header_bytes <= HDR_W'(v);
    do @(posedge clk); while (!cfg_ready);
    hdr_bytes = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    for (int i = 0; i < NBLK; i++) begin
      blk_alloc[i] = 1'b0;
      blk_order[i] = '0;
      blk_next[i] = '0;
      blk_prev[i] = '0;
    end
    for (int i = 0; i < ORDERS; i++) free_head[i] = '0;
    blk_order[0] = ORD_W'(TOP_ORDER);
    free_head[TOP_ORDER] = {1'b1, IDX_W'(0)};
    hdr_bytes = 12;
    errors = 0;
    stall_cnt = 0;
    took = 1'b0;
    idle_ok = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_header_bytes = '0;
    in_operation = 1'b0;
    in_request_bytes = '0;
    in_block_index = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    write_header(12);
    // Whole chunk, then nothing left, then the merge back to one free block.
    add_job(1'b0, 2097139, 0, 1'b0);
    add_job(1'b0, 0, 0, 1'b0);
    add_job(1'b1, 0, 0, 1'b0);
    add_job(1'b1, 0, 0, 1'b0);
    add_job(1'b0, 2097140, 0, 1'b0);
    add_job(1'b0, 2097152, 0, 1'b0);
    add_job(1'b0, (1 << REQ_W) - 1, 0, 1'b0);
    add_job(1'b1, 0, NBLK - 1, 1'b0);
    add_job(1'b0, 0, 0, 1'b0);
    add_job(1'b0, 51, 0, 1'b0);
    add_job(1'b0, 52, 0, 1'b0);
    add_job(1'b0, 5000, 0, 1'b0);
    add_job(1'b1, 0, 3, 1'b0);
    add_job(1'b1, 0, 1, 1'b0);
    add_job(1'b1, 0, 0, 1'b1);
    add_job(1'b1, 0, 0, 1'b1);
    add_job(1'b1, 0, 0, 1'b1);
    add_job(1'b1, 0, 0, 1'b1);
    add_random(400);
    drain();

    write_header(0);
    add_job(1'b0, 2097151, 0, 1'b0);
    add_job(1'b0, 2097152, 0, 1'b0);
    add_job(1'b1, 0, 0, 1'b1);
    add_random(300);
    drain();

    write_header(63);
    add_job(1'b0, 0, 0, 1'b0);
    add_job(1'b0, 1, 0, 1'b0);
    add_random(300);
    drain();

    // A stretch with the sender never idling.
    idle_ok = 1'b0;
    write_header($urandom_range(0, 63));
    add_random(400);
    drain();
    idle_ok = 1'b1;

    write_header($urandom_range(0, 63));
    add_random(400);
    drain();

    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== buddy_block_allocator_top.f =====
hdl/bba_pkg.sv
hdl/bba_table_ram.sv
hdl/bba_ctrl.sv
hdl/buddy_block_allocator_top.sv
sim/testbench.sv
